>>> rtl/assert_macros.svh
// Assertion macros shared by the RTL modules.
// Expects clk and rst_n (active low) to exist in the including module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent check sampled on the rising clock edge, off while in reset.
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Condition that must never hold on a clock edge outside reset.
`define ASSERT_NEVER(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error(msg);

`endif

>>> rtl/wstq_pkg.sv
// Shared types and codes for the work-stealing task queue block.
// No dependencies; imported by every module of the block.
package wstq_pkg;

    typedef struct packed {
        logic        req_type;
        logic [2:0]  thread_id;
        logic [15:0] task_id;
    } wstq_req_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [15:0] task_out;
        logic [2:0]  source_queue;
    } wstq_rsp_t;

    // controller -> datapath
    typedef struct packed {
        logic capture;
        logic execute;
        logic emit;
    } wstq_cmd_t;

    localparam logic REQ_PUSH = 1'b0;
    localparam logic REQ_POP  = 1'b1;

    localparam logic [2:0] ST_LOCAL   = 3'd0;
    localparam logic [2:0] ST_STOLEN  = 3'd1;
    localparam logic [2:0] ST_NONE    = 3'd2;
    localparam logic [2:0] ST_PUSHED  = 3'd3;
    localparam logic [2:0] ST_DROPPED = 3'd4;

    // register index as seen in paddr[2]
    localparam logic REG_ACTIVE_THREADS = 1'b0;

endpackage

>>> rtl/wstq_regs.sv
// APB-style configuration register file: active_threads.
// Depends on wstq_pkg.
module wstq_regs (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    output logic [3:0]  active_threads
);
    import wstq_pkg::*;

    logic [3:0] active_threads_reg;
    logic       wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && (paddr[2] == REG_ACTIVE_THREADS);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_threads_reg <= 4'd1;
        end
        else if (wr_en)
        begin
            active_threads_reg <= pwdata[3:0];
        end
    end

    always_comb
    begin
        unique case (paddr[2])
            REG_ACTIVE_THREADS: prdata = {28'd0, active_threads_reg};
            default:            prdata = 32'd0;
        endcase
    end

    assign active_threads = active_threads_reg;

endmodule

>>> rtl/wstq_ctrl.sv
// Sequencing FSM: accept, decide/memory access, result beat.
// Depends on wstq_pkg and assert_macros.svh.
`include "assert_macros.svh"

module wstq_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    output logic                done,
    output wstq_pkg::wstq_cmd_t cmd
);
    import wstq_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_DECIDE,
        S_RESULT
    } state_t;

    state_t state_reg, state_next;
    logic   busy_reg;
    logic   done_reg;
    logic   accept;

    assign accept = start && !busy_reg;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:   if (accept) state_next = S_DECIDE;
            S_DECIDE: state_next = S_RESULT;
            S_RESULT: state_next = accept ? S_DECIDE : S_IDLE;
            default:  state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            busy_reg  <= (state_next == S_DECIDE);
            done_reg  <= (state_next == S_RESULT);
        end
    end

    assign busy        = busy_reg;
    assign done        = done_reg;
    assign cmd.capture = accept;
    assign cmd.execute = busy_reg;
    assign cmd.emit    = done_reg;

    `ASSERT_CLK(a_accept_busy, start && !busy |=> busy, "accepted beat did not raise busy")
    `ASSERT_CLK(a_decide_result, busy |=> done && !busy, "decide cycle not followed by result")
    `ASSERT_CLK(a_result_cause, done |-> $past(busy), "result beat without a decide cycle")

endmodule

>>> rtl/wstq_dp.sv
// Datapath: per-queue pointers and fill counts, victim pick, task memory.
// Depends on wstq_pkg and assert_macros.svh.
`include "assert_macros.svh"

module wstq_dp #(
    parameter int MAX_THREADS = 8,
    parameter int QUEUE_DEPTH = 16,
    parameter int TASK_BITS   = 16
) (
    input  logic                clk,
    input  logic                rst_n,
    input  wstq_pkg::wstq_cmd_t cmd,
    input  wstq_pkg::wstq_req_t req,
    input  logic [3:0]          active_threads,
    output wstq_pkg::wstq_rsp_t result
);
    import wstq_pkg::*;

    localparam int QW = (MAX_THREADS > 1) ? $clog2(MAX_THREADS) : 1;
    localparam int PW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam int AW = $clog2(MAX_THREADS * QUEUE_DEPTH);

    typedef enum logic [1:0] {
        UPD_NONE,
        UPD_PUSH,
        UPD_FRONT,
        UPD_BACK
    } upd_t;

    // captured request
    logic                 req_type_reg;
    logic [2:0]           tid_reg;
    logic [TASK_BITS-1:0] task_reg;

    // queue state
    logic [PW-1:0] head_reg [MAX_THREADS];
    logic [PW-1:0] tail_reg [MAX_THREADS];
    logic [CW-1:0] fill_reg [MAX_THREADS];

    logic [TASK_BITS-1:0] mem [MAX_THREADS * QUEUE_DEPTH];
    logic [TASK_BITS-1:0] rdata_reg;

    logic [2:0] status_reg, status_next;
    logic [2:0] src_reg, src_next;
    logic       hit_reg, hit_next;

    logic [3:0]             n_thr;
    logic                   tid_ok;
    logic [QW-1:0]          tq;
    logic [CW-1:0]          own_cnt;
    logic                   own_full;
    logic                   own_empty;
    logic [MAX_THREADS-1:0] nonempty;
    logic                   found_hi, found_lo, found;
    logic [QW-1:0]          vq_hi, vq_lo, vq;
    logic [PW-1:0]          back_ptr;
    upd_t                   upd;
    logic                   wr_en;
    logic                   rd_en;
    logic [QW-1:0]          mem_q;
    logic [PW-1:0]          mem_ptr;
    logic [AW-1:0]          addr;

    function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
        return (p == PW'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    function automatic logic [PW-1:0] ptr_dec(input logic [PW-1:0] p);
        return (p == '0) ? PW'(QUEUE_DEPTH - 1) : p - 1'b1;
    endfunction

    // threads in use: zero reads as one, clamp to the queue count
    always_comb
    begin
        if (active_threads == 4'd0)
            n_thr = 4'd1;
        else if (int'(active_threads) > MAX_THREADS)
            n_thr = 4'(MAX_THREADS);
        else
            n_thr = active_threads;
    end

    assign tid_ok    = int'(tid_reg) < int'(n_thr);
    assign tq        = QW'(tid_reg);
    assign own_cnt   = fill_reg[tq];
    assign own_full  = (own_cnt == CW'(QUEUE_DEPTH));
    assign own_empty = (own_cnt == '0);

    // wrapped priority pick: first non-empty queue above the requester,
    // else the first one from queue zero
    always_comb
    begin
        found_hi = 1'b0;
        found_lo = 1'b0;
        vq_hi    = '0;
        vq_lo    = '0;
        for (int q = 0; q < MAX_THREADS; q++)
        begin
            nonempty[q] = (fill_reg[q] != '0) && (q < int'(n_thr));
        end
        for (int q = MAX_THREADS - 1; q >= 0; q--)
        begin
            if (nonempty[q])
            begin
                found_lo = 1'b1;
                vq_lo    = QW'(q);
                if (q > int'(tid_reg))
                begin
                    found_hi = 1'b1;
                    vq_hi    = QW'(q);
                end
            end
        end
    end

    assign found    = found_hi || found_lo;
    assign vq       = found_hi ? vq_hi : vq_lo;
    assign back_ptr = ptr_dec(tail_reg[vq]);

    always_comb
    begin
        status_next = ST_NONE;
        src_next    = 3'd0;
        hit_next    = 1'b0;
        upd         = UPD_NONE;
        wr_en       = 1'b0;
        rd_en       = 1'b0;
        mem_q       = tq;
        mem_ptr     = tail_reg[tq];
        if (req_type_reg == REQ_PUSH)
        begin
            src_next = tid_reg;
            if (!tid_ok || own_full)
            begin
                status_next = ST_DROPPED;
            end
            else
            begin
                status_next = ST_PUSHED;
                upd         = UPD_PUSH;
                wr_en       = 1'b1;
            end
        end
        else if (tid_ok)
        begin
            if (!own_empty)
            begin
                status_next = ST_LOCAL;
                src_next    = tid_reg;
                hit_next    = 1'b1;
                upd         = UPD_FRONT;
                rd_en       = 1'b1;
                mem_ptr     = head_reg[tq];
            end
            else if (found)
            begin
                status_next = ST_STOLEN;
                src_next    = 3'(vq);
                hit_next    = 1'b1;
                upd         = UPD_BACK;
                rd_en       = 1'b1;
                mem_q       = vq;
                mem_ptr     = back_ptr;
            end
        end
    end

    assign addr = AW'(mem_q) * AW'(QUEUE_DEPTH) + AW'(mem_ptr);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int q = 0; q < MAX_THREADS; q++)
            begin
                head_reg[q] <= '0;
                tail_reg[q] <= '0;
                fill_reg[q] <= '0;
            end
            hit_reg <= 1'b0;
        end
        else if (cmd.execute)
        begin
            hit_reg <= hit_next;
            case (upd)
                UPD_PUSH:
                begin
                    tail_reg[tq] <= ptr_inc(tail_reg[tq]);
                    fill_reg[tq] <= own_cnt + 1'b1;
                end
                UPD_FRONT:
                begin
                    head_reg[tq] <= ptr_inc(head_reg[tq]);
                    fill_reg[tq] <= own_cnt - 1'b1;
                end
                UPD_BACK:
                begin
                    tail_reg[vq] <= back_ptr;
                    fill_reg[vq] <= fill_reg[vq] - 1'b1;
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            req_type_reg <= req.req_type;
            tid_reg      <= req.thread_id;
            task_reg     <= TASK_BITS'(req.task_id);
        end
        if (cmd.execute)
        begin
            status_reg <= status_next;
            src_reg    <= src_next;
        end
    end

    // task memory, single port, registered read
    always_ff @(posedge clk)
    begin
        if (cmd.execute && wr_en)
            mem[addr] <= task_reg;
        if (cmd.execute && rd_en)
            rdata_reg <= mem[addr];
    end

    assign result.status       = status_reg;
    assign result.task_out     = hit_reg ? 16'(rdata_reg) : 16'd0;
    assign result.source_queue = src_reg;

    `ASSERT_CLK(a_hit_status, cmd.emit |->
        (hit_reg == (status_reg == ST_LOCAL || status_reg == ST_STOLEN)),
        "task returned without a pop status")
    `ASSERT_CLK(a_ptr_fill, cmd.execute && tid_ok |->
        ((own_empty || own_full) == (head_reg[tq] == tail_reg[tq])),
        "queue pointers disagree with fill count")
    `ASSERT_CLK(a_steal_other, cmd.emit && status_reg == ST_STOLEN |->
        src_reg != tid_reg, "stole from the requester's own queue")

endmodule

>>> rtl/work_stealing_task_queues_top.sv
// Channel   Handshake        Payload                     Notes
// cmd       start / busy     wstq_req_t (type,thr,task)  accepted when start && !busy
// result    done (strobe)    wstq_rsp_t (status,task,q)  one beat per item, no stall
// config    APB psel/penable paddr[2:0], pwdata/prdata   active_threads at 0x0
//
// An item passes the accept edge, then the decide edge that updates the
// queue pointers and issues the single-port task memory access; the result beat
// follows in the next cycle, which may also accept the next item, but a new item
// is not taken during the decide step, while busy is high.
// Reset (rst_n low, async) empties all queues and sets active_threads to 1;
// no memory clearing pass is needed. The result side cannot stall.
// Depends on wstq_pkg, wstq_regs, wstq_ctrl, wstq_dp.
module work_stealing_task_queues_top #(
    parameter int MAX_THREADS = 8,
    parameter int QUEUE_DEPTH = 16,
    parameter int TASK_BITS   = 16
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  wstq_pkg::wstq_req_t cmd,
    output logic                done,
    output wstq_pkg::wstq_rsp_t result,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [2:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);
    import wstq_pkg::*;

    logic [3:0] active_threads;
    wstq_cmd_t  ctl;

    wstq_regs u_regs (
        .clk            (clk),
        .rst_n          (rst_n),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .active_threads (active_threads)
    );

    wstq_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .done  (done),
        .cmd   (ctl)
    );

    wstq_dp #(
        .MAX_THREADS (MAX_THREADS),
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .TASK_BITS   (TASK_BITS)
    ) u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (ctl),
        .req            (cmd),
        .active_threads (active_threads),
        .result         (result)
    );

endmodule
